[hdl/brhid_pkg.sv]
// Shared types and constants for the button and rotary HID event block
package brhid_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int LEVEL_W     = 8;
    localparam int SAMPLE_W    = 16;
    localparam int KEY_INDEX_W = 3;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_W-1:0]    DEBOUNCE_RST  = 16'd100;
    localparam logic [CFG_W-1:0]    HOLDOFF_RST   = 16'd150;
    localparam logic [CFG_W-1:0]    STEP_RST      = 16'd3000;
    localparam logic [CFG_W-1:0]    WRAP_RST      = 16'd15000;
    localparam logic [CFG_W-1:0]    BLINK_RST     = 16'd100;
    localparam logic [LEVEL_W-1:0]  RELEASE_RST   = 8'd10;
    localparam logic [LEVEL_W-1:0]  LED_ON_RST    = 8'd64;
    localparam logic [SAMPLE_W-1:0] NO_REFERENCE  = 16'h8000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_HOLDOFF  = 3'd1,
        REG_STEP     = 3'd2,
        REG_WRAP     = 3'd3,
        REG_BLINK    = 3'd4,
        REG_RELEASE  = 3'd5,
        REG_LED_ON   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                   hit;
        logic [KEY_INDEX_W-1:0] index;
    } edge_pick_t;

    typedef struct packed {
        logic fire;
        logic down;
    } scroll_evt_t;

    typedef struct packed {
        logic                   key_release;
        logic                   key_press;
        logic [KEY_INDEX_W-1:0] key_index;
        logic                   scroll;
        logic                   scroll_minus;
        logic [LEVEL_W-1:0]     led_level;
    } result_t;

endpackage

[hdl/brhid_lane.sv]
// Per-button lane: held history, debounce timer and rising edge acceptance
module brhid_lane
    import brhid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              is_held,
    input  logic [CFG_W-1:0]  gap_ms,
    output logic              accept
);

    logic              was_held_reg;
    logic              was_held_next;
    logic [TIME_W-1:0] last_accept_reg;
    logic [TIME_W-1:0] last_accept_next;
    logic [TIME_W-1:0] elapsed;

    assign elapsed = now_ms - last_accept_reg;
    assign accept  = is_held && !was_held_reg
                     && (elapsed > {{(TIME_W-CFG_W){1'b0}}, gap_ms});

    always_comb
    begin
        was_held_next    = was_held_reg;
        last_accept_next = last_accept_reg;
        if (step)
        begin
            was_held_next = is_held;
            if (accept)
            begin
                last_accept_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_held_reg    <= 1'b0;
            last_accept_reg <= '0;
        end
        else
        begin
            was_held_reg    <= was_held_next;
            last_accept_reg <= last_accept_next;
        end
    end

endmodule

[hdl/brhid_merge.sv]
// Merge stage: pick the lowest-indexed accepted rising edge across lanes
module brhid_merge
    import brhid_pkg::*;
#(
    parameter int BUTTON_COUNT = 6
)
(
    input  logic [BUTTON_COUNT-1:0] accept,
    output edge_pick_t              pick
);

    always_comb
    begin
        pick.hit   = 1'b0;
        pick.index = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--)
        begin
            if (accept[i])
            begin
                pick.hit   = 1'b1;
                pick.index = KEY_INDEX_W'(i);
            end
        end
    end

endmodule

[hdl/brhid_scroll.sv]
// Encoder sample tracking and scroll step detection with hold-off
module brhid_scroll
    import brhid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                host_ready,
    input  logic [CFG_W-1:0]    scroll_holdoff_ms,
    input  logic [CFG_W-1:0]    step_threshold,
    input  logic [CFG_W-1:0]    wrap_threshold,
    output scroll_evt_t         evt
);

    logic [SAMPLE_W-1:0] ref_reg;
    logic [SAMPLE_W-1:0] ref_next;
    logic [TIME_W-1:0]   last_scroll_reg;
    logic [TIME_W-1:0]   last_scroll_next;
    logic [SAMPLE_W:0]   diff_up;
    logic [SAMPLE_W:0]   diff_dn;
    logic                negative;
    logic [SAMPLE_W:0]   mag;
    logic                holdoff_done;
    logic                past_wrap;
    logic                past_step;
    logic                fire;
    logic                down;

    assign diff_up      = {sample[SAMPLE_W-1], sample} - {ref_reg[SAMPLE_W-1], ref_reg};
    assign diff_dn      = {ref_reg[SAMPLE_W-1], ref_reg} - {sample[SAMPLE_W-1], sample};
    assign negative     = diff_up[SAMPLE_W];
    assign mag          = negative ? diff_dn : diff_up;
    assign holdoff_done = (now_ms - last_scroll_reg) > {{(TIME_W-CFG_W){1'b0}}, scroll_holdoff_ms};
    assign past_wrap    = mag > {1'b0, wrap_threshold};
    assign past_step    = mag > {1'b0, step_threshold};
    assign fire         = step && (ref_reg != NO_REFERENCE) && holdoff_done
                          && (past_wrap || past_step);
    assign down         = past_wrap ? negative : !negative;

    assign evt.fire = fire && host_ready;
    assign evt.down = fire && host_ready && down;

    always_comb
    begin
        ref_next         = ref_reg;
        last_scroll_next = last_scroll_reg;
        if (step && (ref_reg == NO_REFERENCE))
        begin
            ref_next = sample;
        end
        else if (fire)
        begin
            ref_next         = sample;
            last_scroll_next = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg         <= NO_REFERENCE;
            last_scroll_reg <= '0;
        end
        else
        begin
            ref_reg         <= ref_next;
            last_scroll_reg <= last_scroll_next;
        end
    end

endmodule

[hdl/button_and_rotary_hid_events.sv]
// Top level: button lanes, tap and LED control, scroll unit, output buffer
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  in      | in_valid/in_ready + poll fields| into block
//  out     | out_valid/out_ready + results  | out of block
//  cfg     | cfg_valid/cfg_ready, index/data| into block
//
// One poll is taken per cycle while in_ready is high. Lanes, merge and scroll
// unit form its result combinationally; it goes to the output register, or to
// the skid entry while that is still held. Reset restores the register
// defaults and clears all history. A two-entry output buffer keeps in_ready
// high while one result waits; in_ready drops only when both are occupied.
module button_and_rotary_hid_events
    import brhid_pkg::*;
#(
    parameter int BUTTON_COUNT = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [TIME_W-1:0]       now_ms,
    input  logic [BUTTON_COUNT-1:0] pressed_mask,
    input  logic                    mounted,
    input  logic                    host_ready,
    input  logic                    sample_valid,
    input  logic signed [SAMPLE_W-1:0] sample,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    key_release,
    output logic                    key_press,
    output logic [KEY_INDEX_W-1:0]  key_index,
    output logic                    scroll,
    output logic                    scroll_minus,
    output logic [LEVEL_W-1:0]      led_level,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    logic [CFG_W-1:0]   debounce_reg;
    logic [CFG_W-1:0]   holdoff_reg;
    logic [CFG_W-1:0]   step_reg;
    logic [CFG_W-1:0]   wrap_reg;
    logic [CFG_W-1:0]   blink_reg;
    logic [LEVEL_W-1:0] release_delay_reg;
    logic [LEVEL_W-1:0] led_on_reg;

    logic               tap_pending_reg;
    logic               tap_pending_next;
    logic [TIME_W-1:0]  release_at_reg;
    logic [TIME_W-1:0]  release_at_next;
    logic               led_lit_reg;
    logic               led_lit_next;
    logic [TIME_W-1:0]  last_blink_reg;
    logic [TIME_W-1:0]  last_blink_next;

    result_t            out_res_reg;
    logic               out_valid_reg;
    result_t            skid_res_reg;
    logic               skid_valid_reg;

    logic                    in_fire;
    logic                    out_fire;
    logic                    lane_step;
    logic [BUTTON_COUNT-1:0] accept;
    edge_pick_t              pick;
    scroll_evt_t             scroll_evt;
    logic [TIME_W-1:0]       release_wait;
    logic                    rel_now;
    logic                    pend_after;
    logic                    press_now;
    logic                    blink_due;
    result_t                 res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign lane_step = in_fire && mounted;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RST;
            holdoff_reg       <= HOLDOFF_RST;
            step_reg          <= STEP_RST;
            wrap_reg          <= WRAP_RST;
            blink_reg         <= BLINK_RST;
            release_delay_reg <= RELEASE_RST;
            led_on_reg        <= LED_ON_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg      <= cfg_data;
                REG_HOLDOFF:  holdoff_reg       <= cfg_data;
                REG_STEP:     step_reg          <= cfg_data;
                REG_WRAP:     wrap_reg          <= cfg_data;
                REG_BLINK:    blink_reg         <= cfg_data;
                REG_RELEASE:  release_delay_reg <= cfg_data[LEVEL_W-1:0];
                REG_LED_ON:   led_on_reg        <= cfg_data[LEVEL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Button lanes
    for (genvar g = 0; g < BUTTON_COUNT; g++)
    begin : g_lane
        brhid_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (lane_step),
            .now_ms      (now_ms),
            .is_held     (pressed_mask[g]),
            .gap_ms      (debounce_reg),
            .accept      (accept[g])
        );
    end

    brhid_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .accept (accept),
        .pick   (pick)
    );

    brhid_scroll u_scroll (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (lane_step && sample_valid),
        .now_ms            (now_ms),
        .sample            (sample),
        .host_ready        (host_ready),
        .scroll_holdoff_ms (holdoff_reg),
        .step_threshold    (step_reg),
        .wrap_threshold    (wrap_reg),
        .evt               (scroll_evt)
    );

    // Tap release, new tap, LED blink
    assign release_wait = now_ms - release_at_reg;
    assign rel_now      = tap_pending_reg && !release_wait[TIME_W-1] && host_ready;
    assign pend_after   = tap_pending_reg && !rel_now;
    assign press_now    = mounted && pick.hit && host_ready && !pend_after;
    assign blink_due    = mounted
                          && ((now_ms - last_blink_reg) > {{(TIME_W-CFG_W){1'b0}}, blink_reg});

    always_comb
    begin
        tap_pending_next = pend_after || press_now;
        release_at_next  = release_at_reg;
        if (press_now)
        begin
            release_at_next = now_ms + {{(TIME_W-LEVEL_W){1'b0}}, release_delay_reg};
        end
        led_lit_next    = led_lit_reg;
        last_blink_next = last_blink_reg;
        if (blink_due)
        begin
            led_lit_next    = (|pressed_mask) ? !led_lit_reg : 1'b1;
            last_blink_next = now_ms;
        end
    end

    always_comb
    begin
        res.key_release  = rel_now;
        res.key_press    = press_now;
        res.key_index    = press_now ? pick.index : '0;
        res.scroll       = mounted && scroll_evt.fire;
        res.scroll_minus = mounted && scroll_evt.down;
        res.led_level    = led_lit_next ? led_on_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_pending_reg <= 1'b0;
            release_at_reg  <= '0;
            led_lit_reg     <= 1'b1;
            last_blink_reg  <= '0;
        end
        else if (in_fire)
        begin
            tap_pending_reg <= tap_pending_next;
            release_at_reg  <= release_at_next;
            led_lit_reg     <= led_lit_next;
            last_blink_reg  <= last_blink_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_res_reg <= res;
            end
            else
            begin
                skid_res_reg <= res;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_res_reg <= skid_res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_release  = out_res_reg.key_release;
    assign key_press    = out_res_reg.key_press;
    assign key_index    = out_res_reg.key_index;
    assign scroll       = out_res_reg.scroll;
    assign scroll_minus = out_res_reg.scroll_minus;
    assign led_level    = out_res_reg.led_level;

`ifndef SYNTHESIS
    skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    down_needs_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.scroll || !out_res_reg.scroll_minus))
        else $error("scroll direction set without scroll step");

    press_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && press_now) |=> tap_pending_reg)
        else $error("tap sent but not left pending");

    release_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && rel_now && !press_now) |=> !tap_pending_reg)
        else $error("tap released but still pending");
`endif

endmodule
